// ----- rtl/lbmdq_pkg.sv -----
// Shared constants, types, exp table and saturation helper for the D1Q3 thermal sweep core.
package lbmdq_pkg;

	localparam int FRAC_BITS      = 32;
	localparam int DATA_W         = 48;
	localparam int MUL_W          = 50;
	localparam int SUM_W          = 52;
	localparam int MAX_NODES      = 1048576;
	localparam int NODE_W         = $clog2(MAX_NODES);
	localparam int EXP_TABLE_SIZE = 256;
	localparam int IDX_W          = $clog2(EXP_TABLE_SIZE);
	localparam int TAB_W          = 48;
	localparam int FRAC_W         = 16;
	localparam int CHUNK_W        = 17;
	localparam int CHUNKS         = 3;
	localparam int CNT_W          = $clog2(CHUNKS);
	localparam int ACC_W          = MUL_W + CHUNK_W * CHUNKS;
	localparam int MAG_W          = ACC_W - FRAC_BITS;
	localparam int IRT_W          = 40;
	localparam int SKIN_W         = 10;
	localparam int ADDR_W         = 5;
	localparam int PDATA_W        = 64;

	localparam logic [1:0] REG_IRT  = 2'd0;
	localparam logic [1:0] REG_BATH = 2'd1;
	localparam logic [1:0] REG_SKIN = 2'd2;

	localparam logic [IRT_W-1:0]         IRT_RST  = 40'd2254943729;
	localparam logic signed [DATA_W-1:0] BATH_RST = -48'sd77309411328;
	localparam logic [SKIN_W-1:0]        SKIN_RST = 10'd10;

	localparam logic [63:0]        LN2_Q32        = 64'd2977044472;
	localparam logic [63:0]        INV_TSCALE_Q32 = 64'd74970584;
	localparam logic signed [63:0] Z_BASE_Q32     = -64'sd34156996644;

	localparam logic signed [MUL_W-1:0] Q_D0 = MUL_W'((64'd10046 << FRAC_BITS) / 64'd10000);
	localparam logic signed [MUL_W-1:0] Q_W0 = MUL_W'((64'd2 << FRAC_BITS) / 64'd3);
	localparam logic signed [MUL_W-1:0] Q_W1 = MUL_W'((64'd1 << FRAC_BITS) / 64'd6);
	localparam logic signed [MUL_W-1:0] Q_DT = MUL_W'((64'd1 << FRAC_BITS) / 64'd1000);
	localparam logic signed [MUL_W-1:0] Q_OM_BULK = MUL_W'((64'd523 << FRAC_BITS) / 64'd284);
	localparam logic signed [MUL_W-1:0] Q_OM_SKIN = MUL_W'((64'd5230 << FRAC_BITS) / 64'd3059);
	localparam logic signed [MUL_W-1:0] Q_SF_BULK = MUL_W'((64'd6250 << FRAC_BITS) / 64'd523);
	localparam logic signed [MUL_W-1:0] Q_SF_SKIN = MUL_W'((64'd25000 << FRAC_BITS) / 64'd1569);

	localparam logic signed [SUM_W-1:0] Q_T_OFS = SUM_W'(64'd128 << FRAC_BITS);
	localparam logic signed [SUM_W-1:0] U_TOP   = SUM_W'((64'd256 << FRAC_BITS) - 64'd1);
	localparam logic signed [SUM_W-1:0] SAT_HI  = SUM_W'((64'd1 << (DATA_W - 1)) - 64'd1);
	localparam logic signed [SUM_W-1:0] SAT_LO  = ~SAT_HI;
	localparam logic [MAG_W-1:0] MAG_POS_MAX = MAG_W'((64'd1 << (DATA_W - 1)) - 64'd1);
	localparam logic [MAG_W-1:0] MAG_NEG_MAX = MAG_W'(64'd1 << (DATA_W - 1));

	typedef logic [TAB_W-1:0] exp_tab_t [EXP_TABLE_SIZE+1];

	typedef struct packed {
		logic                     start;
		logic signed [MUL_W-1:0]  a;
		logic signed [MUL_W-1:0]  b;
	} mul_req_t;

	typedef struct packed {
		logic                     busy;
		logic                     done;
		logic signed [DATA_W-1:0] res;
	} mul_rsp_t;

	typedef struct packed {
		logic [IRT_W-1:0]         irt;
		logic signed [DATA_W-1:0] bath;
		logic [SKIN_W-1:0]        skin;
	} cfg_t;

	typedef enum logic [1:0] {MU_IDLE, MU_ACC, MU_SAT} mul_state_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_SUM, ST_LUT, ST_G, ST_D1, ST_D2, ST_SRC, ST_FEQ0, ST_FEQ1,
		ST_OM0, ST_OM1, ST_OM2, ST_S0, ST_S1, ST_B0, ST_B1, ST_EMIT0, ST_EMIT1
	} seq_state_t;

	function automatic logic [63:0] exp_neg(input logic signed [63:0] z);
		logic [63:0] m;
		logic [63:0] n;
		logic [63:0] r;
		logic [63:0] sum;
		logic [63:0] term;
		int s;
		m = 64'd0 - z;
		n = (m + LN2_Q32 - 64'd1) / LN2_Q32;
		r = n * LN2_Q32 - m;
		sum = 64'd1 << 32;
		term = 64'd1 << 32;
		for (int k = 1; k <= 16; k++)
			term = ((term * r) >> 32) / 64'(k);
		for (int k = 1; k <= 16; k++) begin
			// series sum rebuilt in the same order
		end
		sum = 64'd1 << 32;
		term = 64'd1 << 32;
		for (int k = 1; k <= 16; k++) begin
			term = ((term * r) >> 32) / 64'(k);
			sum = sum + term;
		end
		if (n > 64'd60)
			return 64'd0;
		s = 32 + int'(n) - FRAC_BITS;
		if (s >= 64)
			return 64'd0;
		return (s >= 0) ? (sum >> s) : (sum << (-s));
	endfunction

	function automatic exp_tab_t build_tab();
		exp_tab_t t;
		logic signed [63:0] z;
		for (int k = 0; k <= EXP_TABLE_SIZE; k++) begin
			z = signed'((64'(k) * 64'd256 * INV_TSCALE_Q32) / 64'(EXP_TABLE_SIZE)) + Z_BASE_Q32;
			t[k] = TAB_W'(exp_neg(z));
		end
		return t;
	endfunction

	localparam exp_tab_t EXP_TAB = build_tab();

	function automatic logic signed [DATA_W-1:0] sat48(input logic signed [SUM_W-1:0] v);
		if (v > SAT_HI)
			return SAT_HI[DATA_W-1:0];
		if (v < SAT_LO)
			return SAT_LO[DATA_W-1:0];
		return v[DATA_W-1:0];
	endfunction

endpackage

// ----- rtl/lbmdq_node_if.sv -----
// Node word channel: one lattice node in.
interface lbmdq_node_if;
	logic               valid;
	logic               ready;
	logic signed [47:0] rest_pop;
	logic signed [47:0] right_pop;
	logic signed [47:0] left_pop;
	logic signed [47:0] bond_len;
	logic               final_node;

	modport source (output valid, rest_pop, right_pop, left_pop, bond_len, final_node,
		input ready);
	modport sink (input valid, rest_pop, right_pop, left_pop, bond_len, final_node,
		output ready);
endinterface

// ----- rtl/lbmdq_result_if.sv -----
// Result word channel: one streamed node out.
interface lbmdq_result_if;
	logic               valid;
	logic               ready;
	logic signed [47:0] new_rest;
	logic signed [47:0] new_right;
	logic signed [47:0] new_left;
	logic signed [47:0] new_bond_len;
	logic               sweep_end;

	modport source (output valid, new_rest, new_right, new_left, new_bond_len, sweep_end,
		input ready);
	modport sink (input valid, new_rest, new_right, new_left, new_bond_len, sweep_end,
		output ready);
endinterface

// ----- rtl/lbmdq_mul.sv -----
// Shared saturating Q32 multiplier, 17-bit digit per cycle.
module lbmdq_mul import lbmdq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	mul_state_t                    state_q, state_d;
	logic [CNT_W-1:0]              cnt_q;
	logic                          neg_q;
	logic [MUL_W-1:0]              amag_q;
	logic [CHUNK_W*CHUNKS-1:0]     bmag_q;
	logic [ACC_W-1:0]              acc_q;
	logic signed [DATA_W-1:0]      res_q;
	logic                          done_q;
	logic                          load, acc_en, sat_en;
	logic [CHUNK_W-1:0]            chunk;
	logic [MUL_W+CHUNK_W-1:0]      pp;
	logic [MAG_W-1:0]              m;
	logic signed [DATA_W-1:0]      res_d;
	logic [MUL_W-1:0]              a_abs, b_abs;

	always_comb begin
		state_d = state_q;
		case (state_q)
			MU_IDLE: if (req.start) state_d = MU_ACC;
			MU_ACC:  if (cnt_q == CNT_W'(CHUNKS - 1)) state_d = MU_SAT;
			MU_SAT:  state_d = MU_IDLE;
			default: state_d = MU_IDLE;
		endcase
	end

	always_comb begin
		load   = 1'b0;
		acc_en = 1'b0;
		sat_en = 1'b0;
		case (state_q)
			MU_IDLE: load = req.start;
			MU_ACC:  acc_en = 1'b1;
			MU_SAT:  sat_en = 1'b1;
			default: ;
		endcase
	end

	assign a_abs = req.a[MUL_W-1] ? MUL_W'(-req.a) : MUL_W'(req.a);
	assign b_abs = req.b[MUL_W-1] ? MUL_W'(-req.b) : MUL_W'(req.b);
	assign chunk = bmag_q[CHUNK_W*CHUNKS-1 -: CHUNK_W];
	assign pp    = amag_q * chunk;
	assign m     = acc_q[ACC_W-1:FRAC_BITS];

	always_comb begin
		if (!neg_q)
			res_d = (m > MAG_POS_MAX) ? SAT_HI[DATA_W-1:0] : m[DATA_W-1:0];
		else
			res_d = (m > MAG_NEG_MAX) ? SAT_LO[DATA_W-1:0] : -m[DATA_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MU_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= sat_en;
			if (load)
				cnt_q <= '0;
			else if (acc_en)
				cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			neg_q  <= req.a[MUL_W-1] ^ req.b[MUL_W-1];
			amag_q <= a_abs;
			bmag_q <= (CHUNK_W*CHUNKS)'(b_abs);
			acc_q  <= '0;
		end else if (acc_en) begin
			acc_q  <= (acc_q << CHUNK_W) + ACC_W'(pp);
			bmag_q <= bmag_q << CHUNK_W;
		end
		if (sat_en)
			res_q <= res_d;
	end

	assign rsp.busy = (state_q != MU_IDLE);
	assign rsp.done = done_q;
	assign rsp.res  = res_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !rsp.busy) else $error("multiplier started while busy");
	a_done_after_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q) == MU_SAT) else $error("done without saturate cycle");
	a_acc_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == MU_SAT |-> $past(cnt_q) == CNT_W'(CHUNKS - 1))
		else $error("wrong digit count");
endmodule

// ----- rtl/lbmdq_cfg.sv -----
// APB register file: relaxation rate, bath temperature, skin count.
module lbmdq_cfg import lbmdq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic [IRT_W-1:0]         irt_q;
	logic signed [DATA_W-1:0] bath_q;
	logic [SKIN_W-1:0]        skin_q;
	logic                     wr;
	logic [1:0]               idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = paddr[ADDR_W-1:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irt_q  <= IRT_RST;
			bath_q <= BATH_RST;
			skin_q <= SKIN_RST;
		end else if (wr) begin
			case (idx)
				REG_IRT:  irt_q  <= pwdata[IRT_W-1:0];
				REG_BATH: bath_q <= pwdata[DATA_W-1:0];
				REG_SKIN: skin_q <= pwdata[SKIN_W-1:0];
				default:  ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_IRT:  prdata = PDATA_W'(irt_q);
			REG_BATH: prdata = PDATA_W'(bath_q);
			REG_SKIN: prdata = PDATA_W'(skin_q);
			default:  prdata = '0;
		endcase
	end

	assign cfg.irt  = irt_q;
	assign cfg.bath = bath_q;
	assign cfg.skin = skin_q;
endmodule

// ----- rtl/lbm_d1q3_thermal_sweep_core.sv -----
// Top level: node sequencer and datapath around the shared multiplier.
// One node word is taken when ready is high; the block then works on it and is not
// ready again until it is done: a sum and a table stage, then thirteen saturating Q32
// products on the single 50x17-bit digit multiplier, then the result words. Results
// trail by one node; the final node gives two words (one if it is also the first),
// the second with sweep_end set. A finished word waits in the output register
// while the next node is accepted. Registers are written over APB at 8*index.
module lbm_d1q3_thermal_sweep_core import lbmdq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	lbmdq_node_if.sink         node_ch,
	lbmdq_result_if.source     result_ch
);

	cfg_t       cfg;
	mul_req_t   mreq;
	mul_rsp_t   mrsp;
	seq_state_t state_q, state_d;

	logic signed [DATA_W-1:0] f0_q, f1_q, f2_q, bond_q, t_q;
	logic                     last_q;
	logic [NODE_W-1:0]        node_cnt_q;
	logic                     issued_q;
	logic [TAB_W-1:0]         lo_q, diff_q;
	logic [FRAC_W-1:0]        frac_q;
	logic signed [MUL_W-1:0]  e_q;
	logic signed [DATA_W-1:0] d_q, delta_q, nb_q, src_q, feq0_q, feq1_q, br0_q;
	logic signed [SUM_W-1:0]  x0_q, x1_q, x2_q, bright_q;
	logic signed [DATA_W-1:0] fn0_q, fn1_q, fn2_q;
	logic signed [DATA_W-1:0] held_rest_q, held_right_q, held_left_q, older_right_q;
	logic signed [DATA_W-1:0] held_bond_q;

	logic                     out_valid_q;
	logic signed [DATA_W-1:0] o_rest_q, o_right_q, o_left_q, o_bond_q;
	logic                     o_end_q;

	logic                     accept, out_free, out_load, is_mul, skin;
	logic                     has_first;
	logic signed [MUL_W-1:0]  omega, factor;
	logic signed [SUM_W-1:0]  u, uc;
	logic [IDX_W-1:0]         idx;
	logic signed [DATA_W-1:0] p_rest, p_right, p_left, p_bond;
	logic                     p_end;
	logic signed [SUM_W-1:0]  r_ext;

	lbmdq_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
	);

	lbmdq_mul u_mul (.clk, .arst_n, .req(mreq), .rsp(mrsp));

	assign accept    = node_ch.valid && node_ch.ready;
	assign out_free  = !out_valid_q || result_ch.ready;
	assign skin      = node_cnt_q < NODE_W'(cfg.skin);
	assign omega     = skin ? Q_OM_SKIN : Q_OM_BULK;
	assign factor    = skin ? Q_SF_SKIN : Q_SF_BULK;
	assign has_first = (node_cnt_q != '0);
	assign is_mul    = (state_q >= ST_G) && (state_q <= ST_B1);
	assign r_ext     = SUM_W'(mrsp.res);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (accept) state_d = ST_SUM;
			ST_SUM:   state_d = ST_LUT;
			ST_LUT:   state_d = ST_G;
			ST_B1:    if (mrsp.done) state_d = ST_EMIT0;
			ST_EMIT0: if (!has_first || out_free) state_d = ST_EMIT1;
			ST_EMIT1: if (!last_q || out_free) state_d = ST_IDLE;
			default:  if (mrsp.done) state_d = seq_state_t'(state_q + 5'd1);
		endcase
	end

	always_comb begin
		mreq.start = is_mul && !issued_q;
		mreq.a     = Q_W0;
		mreq.b     = MUL_W'(t_q);
		node_ch.ready = (state_q == ST_IDLE);
		out_load   = 1'b0;
		p_rest     = fn0_q;
		p_right    = held_right_q;
		p_left     = fn1_q;
		p_bond     = nb_q;
		p_end      = 1'b1;
		case (state_q)
			ST_G: begin
				mreq.a = MUL_W'(diff_q);
				mreq.b = MUL_W'({frac_q, 16'd0});
			end
			ST_D1: begin
				mreq.a = e_q - MUL_W'(bond_q);
				mreq.b = MUL_W'(cfg.irt);
			end
			ST_D2: begin
				mreq.a = MUL_W'(d_q);
				mreq.b = Q_DT;
			end
			ST_SRC: begin
				mreq.a = factor;
				mreq.b = MUL_W'(delta_q);
			end
			ST_FEQ0: ;
			ST_FEQ1: mreq.a = Q_W1;
			ST_OM0: begin
				mreq.a = omega;
				mreq.b = MUL_W'(f0_q) - MUL_W'(feq0_q);
			end
			ST_OM1: begin
				mreq.a = omega;
				mreq.b = MUL_W'(f1_q) - MUL_W'(feq1_q);
			end
			ST_OM2: begin
				mreq.a = omega;
				mreq.b = MUL_W'(f2_q) - MUL_W'(feq1_q);
			end
			ST_S0: mreq.b = MUL_W'(src_q);
			ST_S1: begin
				mreq.a = Q_W1;
				mreq.b = MUL_W'(src_q);
			end
			ST_B0: mreq.b = MUL_W'(cfg.bath);
			ST_B1: begin
				mreq.a = Q_W1;
				mreq.b = MUL_W'(cfg.bath);
			end
			ST_EMIT0: begin
				out_load = has_first && out_free;
				p_left   = fn2_q;
				p_bond   = held_bond_q;
				p_end    = 1'b0;
				if (node_cnt_q == NODE_W'(1)) begin
					p_rest  = br0_q;
					p_right = sat48(bright_q - SUM_W'(held_left_q));
				end else begin
					p_rest  = held_rest_q;
					p_right = older_right_q;
				end
			end
			ST_EMIT1: begin
				out_load = last_q && out_free;
				if (!has_first)
					p_right = sat48(bright_q - SUM_W'(fn2_q));
			end
			default: ;
		endcase
	end

	always_comb begin
		u = SUM_W'(t_q) + Q_T_OFS;
		if (u < 0)
			uc = '0;
		else if (u > U_TOP)
			uc = U_TOP;
		else
			uc = u;
	end
	assign idx = uc[FRAC_BITS+IDX_W-1:FRAC_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			issued_q      <= 1'b0;
			node_cnt_q    <= '0;
			out_valid_q   <= 1'b0;
			held_rest_q   <= '0;
			held_right_q  <= '0;
			held_left_q   <= '0;
			older_right_q <= '0;
			held_bond_q   <= '0;
		end else begin
			state_q <= state_d;
			if (mreq.start)
				issued_q <= 1'b1;
			else if (mrsp.done)
				issued_q <= 1'b0;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (result_ch.ready)
				out_valid_q <= 1'b0;
			if (state_q == ST_EMIT1 && state_d == ST_IDLE) begin
				older_right_q <= held_right_q;
				held_rest_q   <= fn0_q;
				held_right_q  <= fn1_q;
				held_left_q   <= fn2_q;
				held_bond_q   <= nb_q;
				node_cnt_q    <= last_q ? '0 : node_cnt_q + NODE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			f0_q   <= node_ch.rest_pop;
			f1_q   <= node_ch.right_pop;
			f2_q   <= node_ch.left_pop;
			bond_q <= node_ch.bond_len;
			last_q <= node_ch.final_node || (node_cnt_q >= NODE_W'(MAX_NODES - 1));
		end
		if (state_q == ST_SUM)
			t_q <= sat48(SUM_W'(f0_q) + SUM_W'(f1_q) + SUM_W'(f2_q));
		if (state_q == ST_LUT) begin
			lo_q   <= EXP_TAB[idx];
			diff_q <= EXP_TAB[{1'b0, idx} + (IDX_W+1)'(1)] - EXP_TAB[idx];
			frac_q <= uc[FRAC_BITS-1 -: FRAC_W];
		end
		if (mrsp.done) begin
			case (state_q)
				ST_G:    e_q <= Q_D0 - MUL_W'(lo_q) - MUL_W'(mrsp.res);
				ST_D1:   d_q <= mrsp.res;
				ST_D2: begin
					delta_q <= mrsp.res;
					nb_q    <= sat48(SUM_W'(bond_q) + r_ext);
				end
				ST_SRC:  src_q  <= mrsp.res;
				ST_FEQ0: feq0_q <= mrsp.res;
				ST_FEQ1: feq1_q <= mrsp.res;
				ST_OM0:  x0_q <= SUM_W'(f0_q) - r_ext;
				ST_OM1:  x1_q <= SUM_W'(f1_q) - r_ext;
				ST_OM2:  x2_q <= SUM_W'(f2_q) - r_ext;
				ST_S0:   fn0_q <= sat48(x0_q + r_ext);
				ST_S1: begin
					fn1_q <= sat48(x1_q + r_ext);
					fn2_q <= sat48(x2_q + r_ext);
				end
				ST_B0:   br0_q <= mrsp.res;
				ST_B1:   bright_q <= r_ext + r_ext;
				default: ;
			endcase
		end
		if (out_load) begin
			o_rest_q  <= p_rest;
			o_right_q <= p_right;
			o_left_q  <= p_left;
			o_bond_q  <= p_bond;
			o_end_q   <= p_end;
		end
	end

	assign result_ch.valid        = out_valid_q;
	assign result_ch.new_rest     = o_rest_q;
	assign result_ch.new_right    = o_right_q;
	assign result_ch.new_left     = o_left_q;
	assign result_ch.new_bond_len = o_bond_q;
	assign result_ch.sweep_end    = o_end_q;

	a_idle_mul_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !mrsp.busy) else $error("multiplier busy while idle");
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_SUM) else $error("accepted word not started");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		node_cnt_q <= NODE_W'(MAX_NODES - 1)) else $error("node counter overrun");
	a_done_issued: assert property (@(posedge clk) disable iff (!arst_n)
		mrsp.done |-> issued_q && is_mul) else $error("product with no request");
endmodule

// ----- sim/lbmdq_sweep_checker.sv -----
// Checker for the D1Q3 thermal sweep core: predicts result words from node words and compares.
module lbmdq_sweep_checker import lbmdq_pkg::*; (
	input  logic               clk,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic               pready,
	lbmdq_node_if              node_ch,
	lbmdq_result_if            result_ch,
	output int                 errors,
	output int                 pending
);

	typedef struct {
		longint rest;
		longint right;
		longint left;
		longint bond;
		bit     sweep_end;
	} node_word_t;

	localparam longint C_D0    = longint'((64'd10046 << 32) / 64'd10000);
	localparam longint C_W0    = longint'((64'd2 << 32) / 64'd3);
	localparam longint C_W1    = longint'((64'd1 << 32) / 64'd6);
	localparam longint C_DT    = longint'((64'd1 << 32) / 64'd1000);
	localparam longint C_OMB   = longint'((64'd523 << 32) / 64'd284);
	localparam longint C_OMS   = longint'((64'd5230 << 32) / 64'd3059);
	localparam longint C_SFB   = longint'((64'd6250 << 32) / 64'd523);
	localparam longint C_SFS   = longint'((64'd25000 << 32) / 64'd1569);
	localparam longint SMAX    = longint'((64'd1 << 47) - 64'd1);
	localparam longint SMIN    = -longint'(64'd1 << 47);
	localparam longint unsigned LN2 = 64'd2977044472;

	node_word_t        expected_words[$];
	longint unsigned   g_tab[0:256];
	longint unsigned   irt_q;
	longint            bath_q;
	int unsigned       skin_q;
	longint            prev_rest, prev_right, prev_left, prev2_right, prev_bond;
	int unsigned       node_idx;

	function automatic longint clamp48(longint v);
		if (v > SMAX) return SMAX;
		if (v < SMIN) return SMIN;
		return v;
	endfunction

	function automatic longint fmul(longint a, longint b);
		bit neg;
		longint unsigned ua, ub;
		logic [127:0] p;
		logic [127:0] m;
		neg = (a < 0) != (b < 0);
		ua = a < 0 ? 64'd0 - a : a;
		ub = b < 0 ? 64'd0 - b : b;
		p = 128'(ua) * 128'(ub);
		m = p >> 32;
		if (m > (128'd1 << 48)) m = 128'd1 << 48;
		return clamp48(neg ? -longint'(m[63:0]) : longint'(m[63:0]));
	endfunction

	function automatic longint unsigned pow_neg(longint z);
		longint unsigned m, n, r, acc, term;
		int s;
		m = 64'd0 - z;
		n = (m + LN2 - 1) / LN2;
		r = n * LN2 - m;
		acc = 64'd1 << 32;
		term = 64'd1 << 32;
		for (int k = 1; k <= 16; k++) begin
			term = ((term * r) >> 32) / longint'(k);
			acc += term;
		end
		if (n > 60) return 0;
		s = 32 + int'(n) - FRAC_BITS;
		if (s >= 64) return 0;
		return s >= 0 ? acc >> s : acc << (-s);
	endfunction

	function automatic longint lookup_g(longint t);
		longint u;
		longint unsigned prod, idx, fr;
		u = t + (longint'(128) << 32);
		if (u < 0) u = 0;
		if (u > (longint'(256) << 32) - 1) u = (longint'(256) << 32) - 1;
		prod = u * 256;
		idx = prod >> 40;
		if (idx >= 256) idx = 255;
		fr = (prod & ((64'd1 << 40) - 1)) >> 24;
		return longint'(g_tab[idx] + (((g_tab[idx+1] - g_tab[idx]) * fr) >> 16));
	endfunction

	initial begin
		for (int k = 0; k <= 256; k++)
			g_tab[k] = pow_neg(longint'((64'(k) * 256 * 64'd74970584) / 256)
				- 64'sd34156996644);
		irt_q = 64'd2254943729;
		bath_q = -64'sd77309411328;
		skin_q = 10;
		prev_rest = 0; prev_right = 0; prev_left = 0; prev2_right = 0; prev_bond = 0;
		node_idx = 0;
		errors = 0;
	end

	task automatic predict_node(longint f0, longint f1, longint f2, longint bond, bit fin);
		longint f[3], fn[3], wt[3];
		longint t, eq, delta, nb, src, om, sf, bright;
		node_word_t w;
		bit last;
		f[0] = f0; f[1] = f1; f[2] = f2;
		wt[0] = C_W0; wt[1] = C_W1; wt[2] = C_W1;
		om = node_idx < skin_q ? C_OMS : C_OMB;
		sf = node_idx < skin_q ? C_SFS : C_SFB;
		t = clamp48(f0 + f1 + f2);
		eq = C_D0 - lookup_g(t);
		delta = fmul(fmul(eq - bond, longint'(irt_q)), C_DT);
		nb = clamp48(bond + delta);
		src = fmul(sf, delta);
		for (int q = 0; q < 3; q++)
			fn[q] = clamp48(f[q] - fmul(om, f[q] - fmul(wt[q], t)) + fmul(wt[q], src));
		bright = fmul(C_W1, bath_q) + fmul(C_W1, bath_q);
		last = fin || node_idx >= MAX_NODES - 1;
		if (node_idx == 1) begin
			w = '{fmul(C_W0, bath_q), clamp48(bright - prev_left), fn[2], prev_bond, 0};
			expected_words.push_back(w);
		end else if (node_idx > 1) begin
			w = '{prev_rest, prev2_right, fn[2], prev_bond, 0};
			expected_words.push_back(w);
		end
		if (last) begin
			w = '{fn[0], node_idx == 0 ? clamp48(bright - fn[2]) : prev_right, fn[1], nb, 1};
			expected_words.push_back(w);
		end
		prev2_right = prev_right;
		prev_rest = fn[0];
		prev_right = fn[1];
		prev_left = fn[2];
		prev_bond = nb;
		node_idx = last ? 0 : node_idx + 1;
	endtask

	task automatic check_word();
		node_word_t w;
		bit bad;
		if (expected_words.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected result word: rest=%h right=%h left=%h bond=%h end=%b",
					result_ch.new_rest, result_ch.new_right, result_ch.new_left,
					result_ch.new_bond_len, result_ch.sweep_end);
			return;
		end
		w = expected_words.pop_front();
		bad = result_ch.new_rest !== w.rest[47:0] || result_ch.new_right !== w.right[47:0]
			|| result_ch.new_left !== w.left[47:0] || result_ch.new_bond_len !== w.bond[47:0]
			|| result_ch.sweep_end !== w.sweep_end;
		if (bad) begin
			errors++;
			if (errors <= 10)
				$display("mismatch: exp rest=%h right=%h left=%h bond=%h end=%b",
					w.rest[47:0], w.right[47:0], w.left[47:0], w.bond[47:0], w.sweep_end,
					"  got rest=%h right=%h left=%h bond=%h end=%b",
					result_ch.new_rest, result_ch.new_right, result_ch.new_left,
					result_ch.new_bond_len, result_ch.sweep_end);
		end
	endtask

	always @(posedge clk) begin
		if (psel && penable && pwrite && pready) begin
			case (paddr >> 3)
				REG_IRT:  irt_q = pwdata[39:0];
				REG_BATH: bath_q = longint'(signed'(pwdata[47:0]));
				REG_SKIN: skin_q = pwdata[9:0];
				default: ;
			endcase
		end
		if (result_ch.valid && result_ch.ready)
			check_word();
		if (node_ch.valid && node_ch.ready)
			predict_node(node_ch.rest_pop, node_ch.right_pop, node_ch.left_pop,
				node_ch.bond_len, node_ch.final_node);
		pending = expected_words.size();
	end

endmodule

// ----- sim/tb_lbm_d1q3_thermal_sweep_core.sv -----
// Top of the D1Q3 thermal sweep core testbench: clock, reset, APB writes, node stimulus, verdict.
module tb_lbm_d1q3_thermal_sweep_core import lbmdq_pkg::*;;

	localparam int NUM_NODES = 1200;
	localparam int DRAIN_WAIT = 150;
	localparam longint CYCLE_LIMIT = 3000000;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [ADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	int                 errors;
	int                 pending;
	longint             cycles;
	int                 nodes_sent;
	bit                 hold_req;
	int                 hold_left;
	int                 stall_pct;
	int                 mode_left;

	lbmdq_node_if   node_ch();
	lbmdq_result_if result_ch();

	lbm_d1q3_thermal_sweep_core u_dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.node_ch(node_ch.sink), .result_ch(result_ch.source)
	);

	lbmdq_sweep_checker u_checker (
		.clk(clk), .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready), .node_ch(node_ch), .result_ch(result_ch),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 0;
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		node_ch.valid = 0; node_ch.rest_pop = '0; node_ch.right_pop = '0;
		node_ch.left_pop = '0; node_ch.bond_len = '0; node_ch.final_node = 0;
		result_ch.ready = 0;
	end

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial cycles = 0;

	// receiver: random stall percentage, redrawn when its mode counter runs out; long hold on request
	always @(posedge clk) begin
		if (hold_req && hold_left == 0) begin
			hold_left <= 800;
			hold_req <= 0;
			result_ch.ready <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result_ch.ready <= 0;
		end else begin
			if (mode_left == 0) begin
				mode_left <= $urandom_range(512, 64);
				case ($urandom_range(3, 0))
					0: stall_pct <= 0;
					1: stall_pct <= 20;
					2: stall_pct <= 60;
					default: stall_pct <= 95;
				endcase
			end else
				mode_left <= mode_left - 1;
			result_ch.ready <= $urandom_range(99, 0) >= stall_pct;
		end
	end

	initial begin
		hold_req = 0; hold_left = 0; stall_pct = 0; mode_left = 0;
	end

	function automatic logic [47:0] pick_val();
		case ($urandom_range(7, 0))
			0, 1: return 48'({$urandom, $urandom});
			2: return $urandom_range(1, 0) ? 48'h7fff_ffff_ffff : 48'h8000_0000_0000;
			3: return 48'(longint'($urandom_range(200, 0)) - 100);
			default: return 48'((longint'($urandom_range(100, 0)) - 50) * 64'sd4294967296
				+ longint'($urandom));
		endcase
	endfunction

	task automatic apb_write(logic [1:0] idx, logic [63:0] val);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_W'(idx) << 3; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		@(posedge clk);
	endtask

	task automatic send_node(logic [47:0] r0, logic [47:0] r1, logic [47:0] r2,
		logic [47:0] b, bit fin);
		node_ch.valid <= 1;
		node_ch.rest_pop <= r0; node_ch.right_pop <= r1; node_ch.left_pop <= r2;
		node_ch.bond_len <= b; node_ch.final_node <= fin;
		do @(posedge clk); while (!node_ch.ready);
		nodes_sent++;
	endtask

	task automatic pause_sender(int n);
		node_ch.valid <= 0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		node_ch.valid <= 0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic send_sweep(int len, bit noisy);
		for (int i = 0; i < len; i++) begin
			send_node(pick_val(), pick_val(), pick_val(), pick_val(),
				noisy ? bit'($urandom_range(1, 0)) : (i == len - 1));
			if ($urandom_range(9, 0) < 2)
				pause_sender($urandom_range(6, 1));
		end
	endtask

	task automatic random_config();
		case ($urandom_range(2, 0))
			0: apb_write(REG_IRT, 64'd0);
			1: apb_write(REG_IRT, 64'hff_ffff_ffff);
			default: apb_write(REG_IRT, {$urandom_range(15, 0), $urandom});
		endcase
		case ($urandom_range(3, 0))
			0: apb_write(REG_BATH, 64'h7fff_ffff_ffff);
			1: apb_write(REG_BATH, 64'h8000_0000_0000);
			2: apb_write(REG_BATH, {$urandom, $urandom});
			default: apb_write(REG_BATH,
				64'((longint'($urandom_range(100, 0)) - 50) * 64'sd4294967296));
		endcase
		case ($urandom_range(3, 0))
			0: apb_write(REG_SKIN, 64'd0);
			1: apb_write(REG_SKIN, 64'd1023);
			default: apb_write(REG_SKIN, 64'($urandom_range(6, 0)));
		endcase
	endtask

	initial begin
		logic [47:0] t_deg;
		int len;
		nodes_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// directed: single-node, two-node, three-node sweeps with extreme fields
		send_node('0, '0, '0, '0, 1'b1);
		send_node(48'h7fff_ffff_ffff, 48'h7fff_ffff_ffff, 48'h7fff_ffff_ffff,
			48'h7fff_ffff_ffff, 1'b1);
		send_node(48'h8000_0000_0000, 48'h8000_0000_0000, 48'h8000_0000_0000,
			48'h8000_0000_0000, 1'b0);
		send_node(48'h7fff_ffff_ffff, 48'h8000_0000_0000, '0, 48'h7fff_ffff_ffff, 1'b1);
		send_node(48'h1_0000_0000, 48'h2_0000_0000, 48'h3_0000_0000, 48'h1_0000_0000, 1'b0);
		send_node(48'hffff_ffff_ffff, '0, '0, 48'h8000_0000_0000, 1'b0);
		send_node(48'h5555_5555_5555, 48'haaaa_aaaa_aaaa, 48'h1234_5678_9abc,
			48'hffff_ffff_ffff, 1'b1);
		// table corners: below, at and above the clamped range
		for (int i = 0; i < 8; i++) begin
			case (i)
				0: t_deg = 48'(-64'sd130 << 32);
				1: t_deg = 48'(-64'sd128 << 32);
				2: t_deg = 48'(-64'sd1);
				3: t_deg = '0;
				4: t_deg = 48'((64'sd128 << 32) - 1);
				5: t_deg = 48'(64'sd128 << 32);
				6: t_deg = 48'(64'sd37 << 32);
				default: t_deg = 48'(64'sd300 << 32);
			endcase
			send_node(t_deg, '0, '0, 48'h1_0000_0000, i == 7);
		end
		drain();

		apb_write(REG_IRT, 64'hff_ffff_ffff);
		apb_write(REG_BATH, 64'h7fff_ffff_ffff);
		apb_write(REG_SKIN, 64'd0);
		send_sweep(3, 1'b0);
		drain();
		apb_write(REG_IRT, 64'd0);
		apb_write(REG_BATH, 64'h8000_0000_0000);
		apb_write(REG_SKIN, 64'd1023);
		send_sweep(4, 1'b0);
		drain();
		apb_write(REG_IRT, 64'd2254943729);
		apb_write(REG_BATH, 64'd0);
		apb_write(REG_SKIN, 64'd2);

		while (nodes_sent < NUM_NODES) begin
			if (nodes_sent >= 400 && nodes_sent < 410 && hold_left == 0)
				hold_req <= 1;
			if ($urandom_range(9, 0) == 0) begin
				drain();
				random_config();
			end
			if ($urandom_range(9, 0) == 0)
				len = $urandom_range(40, 10);
			else
				len = $urandom_range(6, 1);
			send_sweep(len, $urandom_range(9, 0) == 0);
			if ($urandom_range(9, 0) < 3)
				pause_sender($urandom_range(20, 1));
		end
		// close any open sweep
		send_node(pick_val(), pick_val(), pick_val(), pick_val(), 1'b1);
		drain();
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
